FILE: hw/rtl/byte_budget_lru_table_defines.svh
// assertion macros shared by the checker
`ifndef BYTE_BUDGET_LRU_TABLE_DEFINES_SVH
`define BYTE_BUDGET_LRU_TABLE_DEFINES_SVH

// property that holds outside reset
`define BBLT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked also during reset
`define BBLT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/bblt_pkg.sv
// ----------------------------------------------------------------------------
// bblt_pkg
// Types, constants and codes of the byte budget lru table.
// ----------------------------------------------------------------------------
`default_nettype none
package bblt_pkg;
  localparam int Entries = 32;
  localparam int SlotW = $clog2(Entries);
  localparam int CntW = $clog2(Entries + 1);

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_PROBE  = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_REJ  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] key;
    logic [23:0] item_bytes;
    logic [31:0] entry_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_eviction;
    logic [63:0] result_key;
    logic [23:0] result_bytes;
    logic [31:0] result_tag;
    logic [5:0]  entry_count;
    logic [39:0] total_bytes;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_EVSCAN,
    S_EVEMIT,
    S_FREE,
    S_APPLY,
    S_EMIT
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic scan_clr;   // reset scan index
    logic scan_step;  // compare current slot, advance
    logic ev_drop;    // drop oldest found slot
    logic do_insert;
    logic do_touch;
    logic do_remove;
    logic do_clear;
    logic emit;       // write result register
    logic [1:0] status;
    logic ev_result;
    logic found_result;
    logic last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] opcode;
    logic key_zero;
    logic bytes_zero;
    logic limit_zero;
    logic scan_done;
    logic hit;
    logic free_found;
    logic old_found;
    logic over;
    logic out_busy;
  } dp_sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/bblt_if.sv
// ----------------------------------------------------------------------------
// bblt_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface bblt_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bblt_ctrl.sv
// ----------------------------------------------------------------------------
// bblt_ctrl
// Sequencer: search, evict oldest-first, pick a free slot, apply, report.
// ----------------------------------------------------------------------------
`default_nettype none
module bblt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bblt_pkg::dp_sts_t sts,
  output bblt_pkg::dp_cmd_t      cmd
);
  import bblt_pkg::*;

  ctl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts.out_busy) begin
          cmd.last = 1'b1;
          state_nxt = S_IDLE;
          cmd.emit = 1'b1;
          case (sts.opcode)
            OP_INSERT: begin
              if (sts.key_zero || sts.bytes_zero || sts.hit) cmd.status = ST_REJ;
              else begin
                cmd.emit = 1'b0;
                cmd.scan_clr = 1'b1;
                state_nxt = (!sts.limit_zero && sts.over) ? S_EVSCAN : S_FREE;
              end
            end
            OP_LOOKUP, OP_PROBE: begin
              if (sts.opcode == OP_LOOKUP && sts.key_zero) cmd.status = ST_REJ;
              else if (!sts.hit || sts.key_zero) cmd.status = ST_MISS;
              else begin
                cmd.status = ST_OK;
                cmd.found_result = 1'b1;
                cmd.do_touch = (sts.opcode == OP_LOOKUP);
              end
            end
            OP_REMOVE: begin
              if (sts.key_zero) cmd.status = ST_REJ;
              else if (!sts.hit) cmd.status = ST_MISS;
              else begin
                cmd.status = ST_OK;
                cmd.found_result = 1'b1;
                cmd.do_remove = 1'b1;
              end
            end
            OP_CLEAR: begin
              cmd.status = ST_OK;
              cmd.do_clear = 1'b1;
            end
            default: cmd.status = ST_REJ;
          endcase
        end
      end
      S_EVSCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_EVEMIT;
      end
      S_EVEMIT: begin
        if (!sts.out_busy) begin
          cmd.scan_clr = 1'b1;
          if (sts.old_found) begin
            cmd.ev_drop = 1'b1;
            cmd.emit = 1'b1;
            cmd.status = ST_OK;
            cmd.ev_result = 1'b1;
            state_nxt = S_APPLY;
          end else state_nxt = S_FREE;
        end
      end
      S_APPLY: begin
        // totals settle after a drop before the budget is checked again
        cmd.scan_clr = 1'b1;
        state_nxt = sts.over ? S_EVSCAN : S_FREE;
      end
      S_FREE: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          if (sts.free_found) begin
            cmd.status = ST_OK;
            cmd.do_insert = 1'b1;
          end else cmd.status = ST_FULL;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/bblt_dp.sv
// ----------------------------------------------------------------------------
// bblt_dp
// Slot store, recency ranks, byte total and a one-slot-per-cycle scanner.
// ----------------------------------------------------------------------------
`default_nettype none
module bblt_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bblt_pkg::in_item_t in_data,
  input  wire logic               cfg_valid,
  input  wire logic [39:0]        cfg_data,
  input  wire bblt_pkg::dp_cmd_t  cmd,
  output bblt_pkg::dp_sts_t       sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bblt_pkg::out_item_t     out_data
);
  import bblt_pkg::*;

  logic [63:0] key_mem [Entries];
  logic [23:0] bytes_mem [Entries];
  logic [31:0] tag_mem [Entries];
  logic [SlotW-1:0] rank_r [Entries];
  logic [Entries-1:0] valid_r, ordered_r;
  logic [39:0] limit_r, total_r;
  logic [CntW-1:0] count_r;
  in_item_t item_r;
  logic [SlotW:0] idx_r;
  logic hit_r, free_r, old_r;
  logic [SlotW-1:0] hit_slot_r, free_slot_r, old_slot_r, old_rank_r;
  logic [CntW-1:0] ord_cnt_r;
  logic [63:0] rd_key_r;
  logic [23:0] rd_bytes_r;
  logic [31:0] rd_tag_r;
  out_item_t out_r;
  logic out_valid_r;

  logic [SlotW-1:0] idx;
  logic [40:0] need;
  logic [SlotW-1:0] tgt;
  logic [23:0] tgt_bytes;
  logic [39:0] sub_res;
  logic [40:0] add_res;

  assign idx = idx_r[SlotW-1:0];
  assign need = {1'b0, total_r} + {17'd0, item_r.item_bytes};
  assign tgt = cmd.ev_drop ? old_slot_r : hit_slot_r;
  assign tgt_bytes = bytes_mem[tgt];
  assign sub_res = (total_r >= {16'd0, tgt_bytes}) ? total_r - {16'd0, tgt_bytes} : '0;
  assign add_res = {1'b0, total_r} + {17'd0, item_r.item_bytes};

  assign sts.opcode = item_r.opcode;
  assign sts.key_zero = (item_r.key == '0);
  assign sts.bytes_zero = (item_r.item_bytes == '0);
  assign sts.limit_zero = (limit_r == '0);
  assign sts.scan_done = (idx_r == (SlotW+1)'(Entries - 1));
  assign sts.hit = hit_r;
  assign sts.free_found = free_r;
  assign sts.old_found = old_r;
  assign sts.over = need > {1'b0, limit_r};
  assign sts.out_busy = out_valid_r && !out_ready;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= '0;
    else if (cfg_valid) limit_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
  end

  // scanner: key match, first free slot, oldest ordered slot, ordered count
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      idx_r <= '0;
      free_r <= 1'b0;
      old_r <= 1'b0;
      ord_cnt_r <= '0;
      if (cmd.load) hit_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!sts.scan_done) idx_r <= idx_r + 1'b1;
      if (valid_r[idx] && key_mem[idx] == item_r.key && !hit_r) begin
        hit_r <= 1'b1;
        hit_slot_r <= idx;
      end
      if (!valid_r[idx] && !free_r) begin
        free_r <= 1'b1;
        free_slot_r <= idx;
      end
      if (valid_r[idx] && ordered_r[idx]) begin
        ord_cnt_r <= ord_cnt_r + 1'b1;
        if (!old_r || rank_r[idx] < old_rank_r) begin
          old_r <= 1'b1;
          old_slot_r <= idx;
          old_rank_r <= rank_r[idx];
        end
      end
    end
  end

  // slot payload store
  always_ff @(posedge clk) begin
    if (cmd.do_insert) begin
      key_mem[free_slot_r] <= item_r.key;
      bytes_mem[free_slot_r] <= item_r.item_bytes;
      tag_mem[free_slot_r] <= item_r.entry_tag;
    end
  end

  assign rd_key_r = key_mem[tgt];
  assign rd_bytes_r = tgt_bytes;
  assign rd_tag_r = tag_mem[tgt];

  // valid, order, ranks, totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ordered_r <= '0;
      total_r <= '0;
      count_r <= '0;
    end else if (cmd.do_clear) begin
      valid_r <= '0;
      ordered_r <= '0;
      total_r <= '0;
      count_r <= '0;
    end else if (cmd.ev_drop || cmd.do_remove) begin
      valid_r[tgt] <= 1'b0;
      ordered_r[tgt] <= 1'b0;
      total_r <= sub_res;
      count_r <= count_r - 1'b1;
      if (ordered_r[tgt]) begin
        for (int j = 0; j < Entries; j++) begin
          if (valid_r[j] && ordered_r[j] && rank_r[j] > rank_r[tgt])
            rank_r[j] <= rank_r[j] - 1'b1;
        end
      end
    end else if (cmd.do_insert) begin
      valid_r[free_slot_r] <= 1'b1;
      ordered_r[free_slot_r] <= !sts.limit_zero;
      rank_r[free_slot_r] <= SlotW'(ord_cnt_r);
      count_r <= count_r + 1'b1;
      total_r <= add_res[40] ? '1 : add_res[39:0];
    end else if (cmd.do_touch && !sts.limit_zero) begin
      ordered_r[hit_slot_r] <= 1'b1;
      for (int j = 0; j < Entries; j++) begin
        if (ordered_r[hit_slot_r] && valid_r[j] && ordered_r[j] &&
            rank_r[j] > rank_r[hit_slot_r])
          rank_r[j] <= rank_r[j] - 1'b1;
      end
      rank_r[hit_slot_r] <= ordered_r[hit_slot_r] ? SlotW'(ord_cnt_r - 1'b1)
                                                  : SlotW'(ord_cnt_r);
    end
  end

  // result register with post-operation count and total
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status <= cmd.status;
      out_r.is_eviction <= cmd.ev_result;
      out_r.last <= cmd.last;
      out_r.result_key <= (cmd.ev_result || cmd.found_result) ? rd_key_r : '0;
      out_r.result_bytes <= (cmd.ev_result || cmd.found_result) ? rd_bytes_r : '0;
      out_r.result_tag <= (cmd.ev_result || cmd.found_result) ? rd_tag_r : '0;
      if (cmd.do_clear) begin
        out_r.entry_count <= '0;
        out_r.total_bytes <= '0;
      end else if (cmd.ev_drop || cmd.do_remove) begin
        out_r.entry_count <= 6'(count_r - 1'b1);
        out_r.total_bytes <= sub_res;
      end else if (cmd.do_insert) begin
        out_r.entry_count <= 6'(count_r + 1'b1);
        out_r.total_bytes <= add_res[40] ? '1 : add_res[39:0];
      end else begin
        out_r.entry_count <= 6'(count_r);
        out_r.total_bytes <= total_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;
endmodule
`default_nettype wire

FILE: hw/rtl/byte_budget_lru_table.sv
// Lookup, probe, remove and clear: accept, a search scan over all slots, the result.
// Insert: search scan, then eviction scans while over budget (each emits one
// eviction; one that finds nothing ordered ends them), a free slot scan and the
// result. A stalled result register adds its wait. Throughput: one item at a time;
// the next accept comes in the cycle after the final result is queued.
// Reset (rst_n low, synchronous): table empty, totals zero, byte_limit zero.
// ----------------------------------------------------------------------------
// byte_budget_lru_table
// Top level: size weighted lru table with byte budget eviction.
// ----------------------------------------------------------------------------
`default_nettype none
module byte_budget_lru_table (
  input  wire logic clk,
  input  wire logic rst_n,
  bblt_if.sink      in_ch,
  bblt_if.source    out_ch,
  bblt_if.sink      cfg_ch
);
  import bblt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  // sequencer
  bblt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  // datapath
  bblt_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_data(in_ch.data),
    .cfg_valid(cfg_ch.valid), .cfg_data(cfg_ch.data),
    .cmd(cmd), .sts(sts),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule
`default_nettype wire

FILE: hw/rtl/bblt_checker.sv
// ----------------------------------------------------------------------------
// bblt_checker
// Port-level checks of the byte budget lru table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "byte_budget_lru_table_defines.svh"
module bblt_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last,
  input wire logic out_ev,
  input wire logic [1:0] out_status
);
  import bblt_pkg::*;

  // stalled result holds
  `BBLT_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  // eviction is never last and always ok
  `BBLT_ASSERT(a_ev, clk, rst_n, out_valid && out_ev |-> !out_last && out_status == ST_OK, "bad eviction")
  // no new transaction right after one accepted
  `BBLT_ASSERT(a_seq, clk, rst_n, in_valid && in_ready |=> !in_ready, "overlap")
  // nothing valid out of reset
  `BBLT_ASSERT_ALWAYS(a_rst, clk, !rst_n |=> !out_valid, "valid after reset")
endmodule
`default_nettype wire

bind byte_budget_lru_table bblt_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.data.last), .out_ev(out_ch.data.is_eviction),
  .out_status(out_ch.data.status)
);

FILE: dv/bblt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bblt_scoreboard
// Watches the input, result and byte limit channels of the lru table, keeps
// its own copy of the table and recency order, and compares every result
// transaction field by field with the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none
module bblt_scoreboard (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire bblt_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire bblt_pkg::out_item_t out_data,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [39:0]         cfg_data,
  output int                       errors,
  output int                       pending
);
  import bblt_pkg::*;

  localparam logic [39:0] TotalMax = 40'hFF_FFFF_FFFF;

  // model of the table
  logic        tbl_valid   [Entries];
  logic        tbl_ordered [Entries];
  logic [63:0] tbl_key     [Entries];
  logic [23:0] tbl_bytes   [Entries];
  logic [31:0] tbl_tag     [Entries];
  int          tbl_rank    [Entries];
  logic [39:0] byte_sum;
  logic [5:0]  live_count;
  logic [39:0] limit_reg;
  out_item_t   expected_results[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic int find_entry(input logic [63:0] k);
    for (int i = 0; i < Entries; i++) begin
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic int ordered_total();
    int n;
    n = 0;
    for (int i = 0; i < Entries; i++) begin
      if (tbl_valid[i] && tbl_ordered[i]) n++;
    end
    return n;
  endfunction

  function automatic int oldest_entry();
    int best;
    best = -1;
    for (int i = 0; i < Entries; i++) begin
      if (tbl_valid[i] && tbl_ordered[i] &&
          (best < 0 || tbl_rank[i] < tbl_rank[best])) best = i;
    end
    return best;
  endfunction

  task automatic take_out_of_order(input int s);
    if (tbl_ordered[s]) begin
      for (int j = 0; j < Entries; j++) begin
        if (tbl_valid[j] && tbl_ordered[j] && tbl_rank[j] > tbl_rank[s]) tbl_rank[j]--;
      end
      tbl_ordered[s] = 1'b0;
    end
  endtask

  task automatic make_newest(input int s);
    tbl_rank[s]    = ordered_total();
    tbl_ordered[s] = 1'b1;
  endtask

  task automatic drop_entry(input int s);
    take_out_of_order(s);
    tbl_valid[s] = 1'b0;
    byte_sum = (byte_sum >= {16'd0, tbl_bytes[s]}) ? byte_sum - {16'd0, tbl_bytes[s]} : '0;
    if (live_count > 0) live_count--;
  endtask

  task automatic queue_result(input logic [1:0] st, input logic ev, input logic [63:0] k,
                              input logic [23:0] b, input logic [31:0] t, input logic lst);
    out_item_t r;
    r.status       = st;
    r.is_eviction  = ev;
    r.result_key   = k;
    r.result_bytes = b;
    r.result_tag   = t;
    r.entry_count  = live_count;
    r.total_bytes  = byte_sum;
    r.last         = lst;
    expected_results = {expected_results, r};
  endtask

  // expected results of one input transaction
  task automatic predict_table_op(input in_item_t it);
    int s;
    int v;
    logic [40:0] sum;
    case (it.opcode)
      OP_INSERT: begin
        if (it.key == '0 || it.item_bytes == '0 || find_entry(it.key) >= 0) begin
          queue_result(ST_REJ, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          // evict oldest until the new entry fits or nothing ordered is left
          if (limit_reg != '0) begin
            while ({1'b0, byte_sum} + {17'd0, it.item_bytes} > {1'b0, limit_reg}) begin
              v = oldest_entry();
              if (v < 0) break;
              drop_entry(v);
              queue_result(ST_OK, 1'b1, tbl_key[v], tbl_bytes[v], tbl_tag[v], 1'b0);
            end
          end
          s = -1;
          for (int i = 0; i < Entries; i++) begin
            if (!tbl_valid[i]) begin
              s = i;
              break;
            end
          end
          if (s < 0) begin
            queue_result(ST_FULL, 1'b0, '0, '0, '0, 1'b1);
          end else begin
            tbl_valid[s]   = 1'b1;
            tbl_ordered[s] = 1'b0;
            tbl_key[s]     = it.key;
            tbl_bytes[s]   = it.item_bytes;
            tbl_tag[s]     = it.entry_tag;
            if (limit_reg != '0) make_newest(s);
            live_count++;
            sum = {1'b0, byte_sum} + {17'd0, it.item_bytes};
            byte_sum = (sum > {1'b0, TotalMax}) ? TotalMax : sum[39:0];
            queue_result(ST_OK, 1'b0, '0, '0, '0, 1'b1);
          end
        end
      end
      OP_LOOKUP, OP_PROBE: begin
        if (it.opcode == OP_LOOKUP && it.key == '0) begin
          queue_result(ST_REJ, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          s = (it.key == '0) ? -1 : find_entry(it.key);
          if (s < 0) begin
            queue_result(ST_MISS, 1'b0, '0, '0, '0, 1'b1);
          end else begin
            if (it.opcode == OP_LOOKUP && limit_reg != '0) begin
              take_out_of_order(s);
              make_newest(s);
            end
            queue_result(ST_OK, 1'b0, tbl_key[s], tbl_bytes[s], tbl_tag[s], 1'b1);
          end
        end
      end
      OP_REMOVE: begin
        if (it.key == '0) begin
          queue_result(ST_REJ, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          s = find_entry(it.key);
          if (s < 0) begin
            queue_result(ST_MISS, 1'b0, '0, '0, '0, 1'b1);
          end else begin
            drop_entry(s);
            queue_result(ST_OK, 1'b0, tbl_key[s], tbl_bytes[s], tbl_tag[s], 1'b1);
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < Entries; i++) begin
          tbl_valid[i]   = 1'b0;
          tbl_ordered[i] = 1'b0;
        end
        byte_sum   = '0;
        live_count = '0;
        queue_result(ST_OK, 1'b0, '0, '0, '0, 1'b1);
      end
      default: queue_result(ST_REJ, 1'b0, '0, '0, '0, 1'b1);
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  task automatic compare_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // sample all channels at the clock edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < Entries; i++) begin
        tbl_valid[i]   = 1'b0;
        tbl_ordered[i] = 1'b0;
      end
      byte_sum   = '0;
      live_count = '0;
      limit_reg  = '0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) limit_reg = cfg_data;
      if (in_valid && in_ready) predict_table_op(in_data);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result transaction", out_data.result_key, '0);
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 64'(out_data.status), 64'(want.status));
          compare_field("is_eviction", 64'(out_data.is_eviction), 64'(want.is_eviction));
          compare_field("result_key", out_data.result_key, want.result_key);
          compare_field("result_bytes", 64'(out_data.result_bytes), 64'(want.result_bytes));
          compare_field("result_tag", 64'(out_data.result_tag), 64'(want.result_tag));
          compare_field("entry_count", 64'(out_data.entry_count), 64'(want.entry_count));
          compare_field("total_bytes", 64'(out_data.total_bytes), 64'(want.total_bytes));
          compare_field("last", 64'(out_data.last), 64'(want.last));
        end
      end
    end
    pending <= expected_results.size();
  end
endmodule
`default_nettype wire

FILE: dv/tb_byte_budget_lru_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_budget_lru_table
// Drives directed and random table operations under several byte limits,
// with bursty input and a stalling receiver; the checker judges the results.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_byte_budget_lru_table;
  import bblt_pkg::*;

  localparam int IdleLimit  = 6000;
  localparam int HoldCycles = 500;
  localparam int PhaseItems = 75;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   burst_left;
  logic long_hold;
  int   hold_count;
  int   rx_mode;
  int   rx_left;
  logic [63:0] key_pool [24];
  logic [39:0] limits [6];

  bblt_if #(.T(in_item_t))    in_ch ();
  bblt_if #(.T(out_item_t))   out_ch ();
  bblt_if #(.T(logic [39:0])) cfg_ch ();

  byte_budget_lru_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  bblt_scoreboard i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .cfg_data  (cfg_ch.data),
    .errors    (fail_count),
    .pending   (pending)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: changing stall modes, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold) begin
      out_ch.ready <= 1'b0;
      hold_count = hold_count + 1;
      if (hold_count >= HoldCycles) long_hold = 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(10, 80);
      end
      rx_left = rx_left - 1;
      case (rx_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic write_limit(input logic [39:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // one input transaction, in bursts with random gaps
  task automatic send_op(input logic [2:0] op, input logic [63:0] k,
                         input logic [23:0] b, input logic [31:0] t);
    in_item_t it;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left = burst_left - 1;
    it.opcode     = op;
    it.key        = k;
    it.item_bytes = b;
    it.entry_tag  = t;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return key_pool[$urandom_range(0, 23)];
    if (r < 95) return {$urandom, $urandom};
    return '0;
  endfunction

  function automatic logic [23:0] pick_bytes(input logic [39:0] lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 10) return 24'hFF_FFFF;
    if (r < 20) return 24'($urandom);
    if (lim != '0 && lim < 40'd4000) return 24'($urandom_range(1, int'(lim) / 3 + 1));
    return 24'($urandom_range(1, 400));
  endfunction

  // random operation mix; a high insert share fills the table
  task automatic send_random(input int ins_pct, input logic [39:0] lim);
    int r;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    if (r < ins_pct) op = OP_INSERT;
    else if (r < ins_pct + (100 - ins_pct) * 35 / 100) op = OP_LOOKUP;
    else if (r < ins_pct + (100 - ins_pct) * 55 / 100) op = OP_PROBE;
    else if (r < ins_pct + (100 - ins_pct) * 90 / 100) op = OP_REMOVE;
    else if (r < 97 && ins_pct < 60) op = OP_CLEAR;
    else if (r < 97) op = OP_PROBE;
    else op = 3'($urandom_range(5, 7));
    send_op(op, pick_key(), pick_bytes(lim), $urandom);
  endtask

  initial begin
    rst_n        = 1'b0;
    long_hold    = 1'b0;
    hold_count   = 0;
    rx_mode      = 0;
    rx_left      = 0;
    burst_left   = 0;
    idle_cycles  = 0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom} | 64'd1;
    key_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    limits = '{40'd0, 40'd1, 40'hFF_FFFF_FFFF, 40'd1500, 40'd300, 40'd0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rejects, extremes, every operation, bad opcodes
    write_limit('0);
    send_op(OP_INSERT, '0, 24'd5, 32'h1);
    send_op(OP_INSERT, key_pool[1], '0, 32'h2);
    send_op(OP_INSERT, key_pool[1], 24'hFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_INSERT, key_pool[1], 24'd7, 32'h3);
    send_op(OP_INSERT, key_pool[0], 24'd1, 32'h0);
    send_op(OP_LOOKUP, key_pool[1], '0, '0);
    send_op(OP_PROBE, key_pool[0], '0, '0);
    send_op(OP_PROBE, '0, '0, '0);
    send_op(OP_LOOKUP, '0, '0, '0);
    send_op(OP_REMOVE, '0, '0, '0);
    send_op(OP_LOOKUP, key_pool[2], '0, '0);
    send_op(OP_REMOVE, key_pool[1], '0, '0);
    send_op(OP_REMOVE, key_pool[1], '0, '0);
    send_op(3'd5, key_pool[0], 24'd1, '0);
    send_op(3'd6, '0, '0, '0);
    send_op(3'd7, key_pool[0], '0, '0);
    send_op(OP_CLEAR, '0, '0, '0);
    send_op(OP_INSERT, key_pool[3], 24'd100, 32'hA5A5_5A5A);
    wait_drained();
    // unordered entry gets ordered by a lookup, then evicted under a limit
    write_limit(40'd150);
    send_op(OP_LOOKUP, key_pool[3], '0, '0);
    send_op(OP_INSERT, key_pool[4], 24'd120, 32'h5A5A_A5A5);
    send_op(OP_INSERT, key_pool[5], 24'd200, 32'h1234_5678);
    send_op(OP_CLEAR, '0, '0, '0);
    wait_drained();

    // random phases under several limits
    for (int p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      if (p == 2) long_hold = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        send_random((p == 0 || p == 2) ? 60 : 45, limits[p]);
      end
      wait_drained();
    end

    repeat (150) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
